// ===== rtl/b64_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the sextet-to-ASCII mapping for the Base64 encoder.
// No dependencies; used by every module of the block.
package b64_pkg;

	// Depth of the group queue between the front and back parts.
	localparam int GroupQueueDepth = 2;

	// ASCII '=' used to pad a short final group.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Mask for one six-bit sextet.
	localparam logic [5:0] SEXTET_MASK = 6'h3F;

	// Number of message bytes carried in a group.
	localparam logic [1:0] GROUP_ONE_BYTE = 2'd1;
	localparam logic [1:0] GROUP_TWO_BYTES = 2'd2;
	localparam logic [1:0] GROUP_FULL = 2'd3;

	// One raw message byte with its end-of-message flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	// One encoded character with its end-of-message flag.
	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} char_item_t;

	// A zero-filled 24-bit group ready for encoding.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        last;
	} group_t;

	// Map a sextet onto the standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
		logic [7:0] v;
		logic [7:0] c;
		v = {2'b00, sextet & SEXTET_MASK};
		if (v < 8'd26) begin
			c = 8'h41 + v;
		end else if (v < 8'd52) begin
			c = 8'h47 + v;
		end else if (v < 8'd62) begin
			c = v - 8'd4;
		end else if (v == 8'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

// ===== rtl/b64_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts message bytes, gathers them into three-byte groups and
// pushes each finished group into the queue. Depends on b64_pkg.
module b64_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64_pkg::byte_item_t byte_item,
	output logic                q_push,
	output b64_pkg::group_t     q_wr,
	input  logic                q_ready
);

	logic [1:0]  pending_count_q;
	logic [15:0] pending_bytes_q;
	logic        accept;
	logic        emit;

	// Hold off new bytes while the queue has no room.
	assign byte_stall = !q_ready;
	assign accept = byte_valid && !byte_stall;

	// A group leaves when it is complete or when the message ends.
	// A count above two cannot occur; it is handled as two.
	assign emit = pending_count_q[1] || byte_item.last_byte;
	assign q_push = accept && emit;

	// Build the zero-filled group from the waiting bytes and the new one.
	always_comb begin
		q_wr.last = byte_item.last_byte;
		if (pending_count_q[1]) begin
			q_wr.bits = {pending_bytes_q, byte_item.data_byte};
			q_wr.nbytes = b64_pkg::GROUP_FULL;
		end else if (pending_count_q[0]) begin
			q_wr.bits = {pending_bytes_q[7:0], byte_item.data_byte, 8'h00};
			q_wr.nbytes = b64_pkg::GROUP_TWO_BYTES;
		end else begin
			q_wr.bits = {byte_item.data_byte, 16'h0000};
			q_wr.nbytes = b64_pkg::GROUP_ONE_BYTE;
		end
	end

	// Pending byte storage; cleared whenever a group leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_count_q <= 2'd0;
			pending_bytes_q <= 16'h0000;
		end else if (accept) begin
			if (emit) begin
				pending_count_q <= 2'd0;
				pending_bytes_q <= 16'h0000;
			end else begin
				pending_count_q <= pending_count_q + 2'd1;
				pending_bytes_q <= {pending_bytes_q[7:0], byte_item.data_byte};
			end
		end
	end

endmodule

// ===== rtl/b64_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue of groups between the front and back parts.
// Depends on b64_pkg for the group type.
module b64_queue #(
	parameter int DEPTH = b64_pkg::GroupQueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64_pkg::group_t wr_data,
	output logic            ready,
	input  logic            pop,
	output b64_pkg::group_t rd_data,
	output logic            valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64_pkg::group_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  level_q;
	logic              do_push;
	logic              do_pop;

	assign ready = (level_q != CNT_W'(DEPTH));
	assign valid = (level_q != '0);
	assign do_push = push && ready;
	assign do_pop = pop && valid;
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/b64_back.sv =====
`timescale 1ns / 1ps
// Back part: takes one group at a time from the queue and sends its four
// characters registered, one per cycle while not stalled. Depends on b64_pkg.
module b64_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  b64_pkg::group_t     q_rd,
	output logic                q_pop,
	output logic                char_valid,
	input  logic                char_stall,
	output b64_pkg::char_item_t char_item
);

	localparam logic [1:0] LAST_SEXTET = 2'd3;

	b64_pkg::group_t     grp_q;
	logic                busy_q;
	logic [1:0]          char_idx_q;
	logic                out_valid_q;
	b64_pkg::char_item_t out_q;
	logic                adv;
	logic                finishing;
	logic [7:0]          cur_char;

	// The output register can take a new character when empty or being drained.
	assign adv = !out_valid_q || !char_stall;
	assign finishing = busy_q && adv && (char_idx_q == LAST_SEXTET);
	assign q_pop = q_valid && (!busy_q || finishing);

	assign char_valid = out_valid_q;
	assign char_item = out_q;

	// Select the character for the current sextet, padding short groups.
	always_comb begin
		case (char_idx_q)
			2'd0: cur_char = b64_pkg::sextet_char(grp_q.bits[23:18]);
			2'd1: cur_char = b64_pkg::sextet_char(grp_q.bits[17:12]);
			2'd2: cur_char = (grp_q.nbytes == b64_pkg::GROUP_ONE_BYTE) ?
				b64_pkg::PAD_CHAR : b64_pkg::sextet_char(grp_q.bits[11:6]);
			2'd3: cur_char = (grp_q.nbytes == b64_pkg::GROUP_FULL) ?
				b64_pkg::sextet_char(grp_q.bits[5:0]) : b64_pkg::PAD_CHAR;
			default: cur_char = b64_pkg::PAD_CHAR;
		endcase
	end

	// Group and output payload registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q <= q_rd;
		end
		if (busy_q && adv) begin
			out_q.out_char <= cur_char;
			out_q.last_char <= grp_q.last && (char_idx_q == LAST_SEXTET);
		end
	end

	// Sequencer control: busy flag, sextet index and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			char_idx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (busy_q && adv) begin
				char_idx_q <= char_idx_q + 2'd1;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// Base64 stream encoder, top level. The first character of a group passes through
// the queue entry, the group register and the output register after the byte that
// completes or ends the group is accepted. The back sequencer sends one character per
// cycle while char_stall is low, four characters per group.
// Reset: arst_n clears pending bytes, queue pointers and output valid at once.
// Depends on b64_pkg, b64_front, b64_queue and b64_back.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64_pkg::GroupQueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64_pkg::byte_item_t byte_item,
	output logic                char_valid,
	input  logic                char_stall,
	output b64_pkg::char_item_t char_item
);

	logic            q_push;
	logic            q_ready;
	logic            q_pop;
	logic            q_valid;
	b64_pkg::group_t q_wr;
	b64_pkg::group_t q_rd;

	// Byte gathering.
	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_push     (q_push),
		.q_wr       (q_wr),
		.q_ready    (q_ready)
	);

	// Group queue.
	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.ready   (q_ready),
		.pop     (q_pop),
		.rd_data (q_rd),
		.valid   (q_valid)
	);

	// Character sequencing.
	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_rd       (q_rd),
		.q_pop      (q_pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

	// The front never pushes a group into a full queue.
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("group pushed into full queue");

	// The back never pops an empty queue.
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("group popped from empty queue");

	// Only the final group of a message may be short, and no group is empty.
	a_short_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> ((q_wr.nbytes == b64_pkg::GROUP_FULL) ||
			(q_wr.last && (q_wr.nbytes != 2'd0))))
		else $error("short group pushed without message end");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder: directed byte rows, then random messages.
// Encodes every accepted byte with its own Base64 encoder and compares characters in order.
// Depends on b64_pkg and the base64_stream_encoder RTL.
module tb_top;

	// Watchdog limit: cycles in a row with no transaction on either channel.
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		b64_pkg::byte_item_t item;
		bit                  typed;
		logic [31:0]         chars;
	} byte_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	b64_pkg::byte_item_t byte_item = '0;
	logic                char_valid;
	logic                char_stall = 1'b0;
	b64_pkg::char_item_t char_item;

	// Encoder state kept alongside the block.
	logic [1:0]  held_count = 2'd0;
	logic [15:0] held_bytes = 16'h0000;
	string       alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	b64_pkg::char_item_t expected_chars[$];
	byte_row_t           directed_rows[$];
	int                  error_count = 0;
	int                  bytes_sent = 0;
	int                  send_idle_pct = 14;
	int                  recv_stall_pct = 83;
	bit                  hold_wanted = 1'b0;

	base64_stream_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item (char_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Encode one byte: returns 0 while a group is still filling, else 4 characters.
	function automatic int encode_byte(input b64_pkg::byte_item_t b,
			output b64_pkg::char_item_t chars[4]);
		logic [23:0] group;
		int          nvalid;
		if (held_count == 2'd2) begin
			group = {held_bytes, b.data_byte};
			nvalid = 3;
		end else if (b.last_byte) begin
			if (held_count == 2'd1) begin
				group = {held_bytes[7:0], b.data_byte, 8'h00};
				nvalid = 2;
			end else begin
				group = {b.data_byte, 16'h0000};
				nvalid = 1;
			end
		end else begin
			held_bytes = {held_bytes[7:0], b.data_byte};
			held_count = held_count + 2'd1;
			return 0;
		end
		for (int i = 0; i < 4; i++) begin
			chars[i].out_char = alphabet[group[23 - 6 * i -: 6]];
			chars[i].last_char = 1'b0;
		end
		if (nvalid < 2) begin
			chars[2].out_char = b64_pkg::PAD_CHAR;
		end
		if (nvalid < 3) begin
			chars[3].out_char = b64_pkg::PAD_CHAR;
		end
		chars[3].last_char = b.last_byte;
		held_count = 2'd0;
		held_bytes = 16'h0000;
		return 4;
	endfunction

	function automatic void add_row(input logic [7:0] data, input logic last, input bit typed,
			input logic [31:0] chars);
		byte_row_t row;
		row.item.data_byte = data;
		row.item.last_byte = last;
		row.typed = typed;
		row.chars = chars;
		directed_rows.push_back(row);
	endfunction

	// Offer one byte, wait for its transaction, then queue the characters it produces.
	task automatic send_byte(input b64_pkg::byte_item_t item, input bit typed,
			input logic [31:0] chars);
		b64_pkg::char_item_t predicted[4];
		int                  n;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= item;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
		bytes_sent++;
		n = encode_byte(item, predicted);
		for (int i = 0; i < n; i++) begin
			if (typed) begin
				predicted[i].out_char = chars[31 - 8 * i -: 8];
				predicted[i].last_char = (i == 3) ? item.last_byte : 1'b0;
			end
			expected_chars.push_back(predicted[i]);
		end
	endtask

	// Random message of random length; content leans on the all-zero and all-one bytes.
	task automatic send_message();
		b64_pkg::byte_item_t item;
		int                  len;
		len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: item.data_byte = 8'h00;
				1: item.data_byte = 8'hFF;
				default: item.data_byte = 8'($urandom_range(255));
			endcase
			item.last_byte = (i == len - 1);
			send_byte(item, 1'b0, 32'h0);
		end
	endtask

	// Receiver: check each character transaction, then pick the next stall value.
	initial begin
		int                  hold_left;
		bit                  hold_taken;
		b64_pkg::char_item_t want;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected character: out_char %h last_char %b",
						char_item.out_char, char_item.last_char);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (char_item.out_char !== want.out_char) begin
						$error("out_char: expected %h, actual %h", want.out_char,
							char_item.out_char);
						error_count++;
					end
					if (char_item.last_char !== want.last_char) begin
						$error("last_char: expected %b, actual %b", want.last_char,
							char_item.last_char);
						error_count++;
					end
				end
			end
			if (hold_left > 0) begin
				char_stall <= 1'b1;
				hold_left--;
			end else if (hold_wanted && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				char_stall <= 1'b1;
			end else begin
				char_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: give up when neither channel has moved for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed rows, then three random phases with different idling.
	initial begin
		int target;
		// Single-byte messages after reset, at both extremes.
		add_row(8'h00, 1'b1, 1'b1, "AA==");
		add_row(8'hFF, 1'b1, 1'b1, "/w==");
		// Two-byte message.
		add_row(8'hFF, 1'b0, 1'b0, 32'h0);
		add_row(8'hFF, 1'b1, 1'b1, "//8=");
		// Exact three-byte message.
		add_row(8'h00, 1'b0, 1'b0, 32'h0);
		add_row(8'h00, 1'b0, 1'b0, 32'h0);
		add_row(8'h00, 1'b1, 1'b1, "AAAA");
		// Full group that is not the end, then a short final group.
		add_row(8'hFF, 1'b0, 1'b0, 32'h0);
		add_row(8'hFF, 1'b0, 1'b0, 32'h0);
		add_row(8'hFF, 1'b0, 1'b1, "////");
		add_row(8'hFF, 1'b1, 1'b1, "/w==");
		// Full group followed by a two-byte tail.
		add_row(8'h4D, 1'b0, 1'b0, 32'h0);
		add_row(8'h61, 1'b0, 1'b0, 32'h0);
		add_row(8'h6E, 1'b0, 1'b1, "TWFu");
		add_row(8'h4D, 1'b0, 1'b0, 32'h0);
		add_row(8'h61, 1'b1, 1'b1, "TWE=");
		// Mixed content, checked against the encoder.
		add_row(8'hFB, 1'b0, 1'b0, 32'h0);
		add_row(8'hEF, 1'b0, 1'b0, 32'h0);
		add_row(8'hBE, 1'b1, 1'b0, 32'h0);
		add_row(8'h14, 1'b0, 1'b0, 32'h0);
		add_row(8'hFB, 1'b1, 1'b0, 32'h0);
		add_row(8'h9C, 1'b0, 1'b0, 32'h0);
		add_row(8'h03, 1'b0, 1'b0, 32'h0);
		add_row(8'hD9, 1'b0, 1'b0, 32'h0);
		add_row(8'h7E, 1'b1, 1'b0, 32'h0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].chars);
		end

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct <= 83;
				recv_stall_pct <= 14;
			end else if (phase == 2) begin
				send_idle_pct <= 0;
				recv_stall_pct <= 0;
				hold_wanted <= 1'b1;
			end
			target = bytes_sent + 58;
			while (bytes_sent < target) begin
				send_message();
			end
		end
		byte_valid <= 1'b0;

		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
